FILE: hw/rtl/olirs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olirs_pkg - shared types and constants of the ordered list
// Capacity, entry layout, opcodes and the per-cell update modes.
// ----------------------------------------------------------------------------
package olirs_pkg;

	// number of list cells
	localparam int CAPACITY = 16;

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int COUNT_W  = 5;

	// held count must reach CAPACITY itself
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// common width for comparing positions, counts and cell indexes
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_GET_KEY = 3'd2,
		OP_GET_POS = 3'd3,
		OP_REM_KEY = 3'd4,
		OP_REM_POS = 3'd5
	} op_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_LOAD,
		CM_FROM_LOWER,
		CM_FROM_UPPER
	} cell_mode_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KEY_W-1:0]    key;
	} entry_t;

	typedef struct packed {
		cell_mode_t mode;
	} cell_ctl_t;

endpackage

FILE: hw/rtl/olirs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olirs_if - command and response channels of the ordered list
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface olirs_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [olirs_pkg::OP_W-1:0]       opcode;
	logic [olirs_pkg::POS_W-1:0]      position;
	logic [olirs_pkg::KEY_W-1:0]      key;
	logic [olirs_pkg::HANDLE_W-1:0]   handle;

	modport source (output valid, opcode, position, key, handle, input ready);
	modport sink   (input valid, opcode, position, key, handle, output ready);
endinterface

interface olirs_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic [olirs_pkg::HANDLE_W-1:0]   entry_handle;
	logic [olirs_pkg::KEY_W-1:0]      entry_key;
	logic [olirs_pkg::COUNT_W-1:0]    entry_count;

	modport source (output valid, ok, entry_handle, entry_key, entry_count, input ready);
	modport sink   (input valid, ok, entry_handle, entry_key, entry_count, output ready);
endinterface

FILE: hw/rtl/olirs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olirs_cell - one slot of the ordered list
// Holds one entry, compares it with the search key and loads a new entry
// or a neighbor's entry as the list shifts up or down.
// ----------------------------------------------------------------------------
module olirs_cell (
	input  logic                        clk,
	input  olirs_pkg::cell_ctl_t        ctl,
	input  olirs_pkg::entry_t           new_entry,
	input  olirs_pkg::entry_t           lower,
	input  olirs_pkg::entry_t           upper,
	input  logic [olirs_pkg::KEY_W-1:0] search_key,
	output olirs_pkg::entry_t           data,
	output logic                        hit
);

	olirs_pkg::entry_t data_q;

	// slot register; contents above the count are don't-care
	always_ff @(posedge clk) begin
		case (ctl.mode)
			olirs_pkg::CM_LOAD:       data_q <= new_entry;
			olirs_pkg::CM_FROM_LOWER: data_q <= lower;
			olirs_pkg::CM_FROM_UPPER: data_q <= upper;
			default:                  data_q <= data_q;
		endcase
	end

	assign data = data_q;
	assign hit  = (data_q.key == search_key);

endmodule

FILE: hw/rtl/ordered_list_insert_remove_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search - shift-register ordered list
// Row of cells holding handle/key entries; append, insert, get and remove
// by key or by position, one command per transfer, one response each.
//
//   channel | dir | payload
//   --------+-----+----------------------------------------------
//   cmd     | in  | opcode, position, key, handle
//   rsp     | out | ok, entry_handle, entry_key, entry_count
//
// One command per cycle unless stalled: all cells compare and shift in the
// same cycle, the response is registered and shows in the cycle after the
// transfer. Reset empties the list (count to zero); slot contents are not
// cleared. A stalled response holds; cmd.ready is low only while it waits.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_search (
	input logic         clk,
	input logic         arst_n,
	olirs_cmd_if.sink   cmd,
	olirs_rsp_if.source rsp
);

	localparam int N = olirs_pkg::CAPACITY;
	localparam int W = olirs_pkg::CMP_W;

	logic [olirs_pkg::CNT_W-1:0] count_q;
	logic [olirs_pkg::CNT_W-1:0] count_nxt;
	logic                        rsp_valid_q;
	logic                        ok_q;
	olirs_pkg::entry_t           entry_q;
	logic [olirs_pkg::COUNT_W-1:0] cnt_out_q;

	olirs_pkg::entry_t    cell_data [N];
	olirs_pkg::cell_ctl_t cell_ctl  [N];
	olirs_pkg::entry_t    cell_lower[N];
	olirs_pkg::entry_t    cell_upper[N];
	olirs_pkg::entry_t    new_entry;
	olirs_pkg::entry_t    rd_entry;
	logic [N-1:0]         hit;

	logic         accept;
	logic [W-1:0] pos_w;
	logic [W-1:0] cnt_w;
	logic [N-1:0] sel_pos, above_pos, sel_cnt, live;
	logic [N-1:0] hit_live, first_hit, above_hit;
	logic [N-1:0] rd_sel, ld_mask, lo_mask, up_mask;
	logic         found, full, ok, is_read, grow, shrink;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign new_entry.handle = cmd.handle;
	assign new_entry.key    = cmd.key;
	assign pos_w            = W'(cmd.position);
	assign cnt_w            = W'(count_q);
	assign full             = (count_q == olirs_pkg::CNT_W'(N));

	// per-cell position masks
	always_comb begin
		for (int i = 0; i < N; i++) begin
			sel_pos[i]   = (W'(i) == pos_w);
			above_pos[i] = (W'(i) > pos_w);
			sel_cnt[i]   = (W'(i) == cnt_w);
			live[i]      = (W'(i) < cnt_w);
		end
	end

	// first live cell with a matching key, and the cells past it
	assign hit_live  = hit & live;
	assign first_hit = hit_live & (~hit_live + N'(1));
	assign above_hit = ~(first_hit | (first_hit - N'(1)));
	assign found     = |hit_live;

	// command decode
	always_comb begin
		ok      = 1'b0;
		is_read = 1'b0;
		grow    = 1'b0;
		shrink  = 1'b0;
		rd_sel  = '0;
		ld_mask = '0;
		lo_mask = '0;
		up_mask = '0;
		case (cmd.opcode)
			olirs_pkg::OP_APPEND: begin
				ok      = !full;
				grow    = 1'b1;
				ld_mask = sel_cnt;
			end
			olirs_pkg::OP_INSERT: begin
				ok      = !full && (pos_w <= cnt_w);
				grow    = 1'b1;
				ld_mask = sel_pos;
				lo_mask = above_pos;
			end
			olirs_pkg::OP_GET_KEY: begin
				ok      = found;
				is_read = 1'b1;
				rd_sel  = first_hit;
			end
			olirs_pkg::OP_GET_POS: begin
				ok      = (pos_w < cnt_w);
				is_read = 1'b1;
				rd_sel  = sel_pos;
			end
			olirs_pkg::OP_REM_KEY: begin
				ok      = found;
				is_read = 1'b1;
				shrink  = 1'b1;
				rd_sel  = first_hit;
				up_mask = first_hit | above_hit;
			end
			olirs_pkg::OP_REM_POS: begin
				ok      = (pos_w < cnt_w);
				is_read = 1'b1;
				shrink  = 1'b1;
				rd_sel  = sel_pos;
				up_mask = sel_pos | above_pos;
			end
			default: ok = 1'b0;
		endcase
	end

	// cell controls and neighbor wiring
	always_comb begin
		for (int i = 0; i < N; i++) begin
			cell_ctl[i].mode = olirs_pkg::CM_HOLD;
			if (accept && ok) begin
				if (ld_mask[i])
					cell_ctl[i].mode = olirs_pkg::CM_LOAD;
				else if (lo_mask[i])
					cell_ctl[i].mode = olirs_pkg::CM_FROM_LOWER;
				else if (up_mask[i])
					cell_ctl[i].mode = olirs_pkg::CM_FROM_UPPER;
			end
			cell_lower[i] = (i == 0)     ? '0 : cell_data[(i == 0) ? 0 : i - 1];
			cell_upper[i] = (i == N - 1) ? '0 : cell_data[(i == N - 1) ? i : i + 1];
		end
	end

	// read mux: OR of the selected cell
	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < N; i++) begin
			if (rd_sel[i])
				rd_entry = rd_entry | cell_data[i];
		end
	end

	// next count
	always_comb begin
		count_nxt = count_q;
		if (ok && grow)
			count_nxt = count_q + olirs_pkg::CNT_W'(1);
		else if (ok && shrink)
			count_nxt = count_q - olirs_pkg::CNT_W'(1);
	end

	// the row of cells
	for (genvar g = 0; g < N; g++) begin : g_cell
		olirs_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.new_entry  (new_entry),
			.lower      (cell_lower[g]),
			.upper      (cell_upper[g]),
			.search_key (cmd.key),
			.data       (cell_data[g]),
			.hit        (hit[g])
		);
	end

	// count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok;
			entry_q   <= (ok && is_read) ? rd_entry : '0;
			cnt_out_q <= olirs_pkg::COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = ok_q;
	assign rsp.entry_handle = entry_q.handle;
	assign rsp.entry_key    = entry_q.key;
	assign rsp.entry_count  = cnt_out_q;

endmodule
